/* src/csmacd_pkg.sv */
package csmacd_pkg;

   localparam int FRAME_DEPTH     = 256;
   localparam int ADDR_W          = $clog2(FRAME_DEPTH);
   localparam int LEN_W           = $clog2(FRAME_DEPTH + 1);
   localparam int BACKOFF_EXP_CAP = 10;
   localparam int EXP_W           = $clog2(BACKOFF_EXP_CAP + 1);
   localparam int MAX_JAM         = 16;

   localparam int SLOT_W  = 10;
   localparam int LIMIT_W = 16;
   localparam int ATT_W   = 5;
   localparam int JAM_W   = 5;
   localparam int BYTE_W  = 8;
   localparam int SEQ_W   = 8;
   localparam int COLL_W  = 16;
   localparam int LFSR_W  = 16;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 3;

   localparam int DELAY_W = (BACKOFF_EXP_CAP + SLOT_W > LIMIT_W) ?
                            (BACKOFF_EXP_CAP + SLOT_W) : LIMIT_W;

   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_REPLY = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [1:0] ST_PROGRESS = 2'd0;
   localparam logic [1:0] ST_SENT     = 2'd1;
   localparam logic [1:0] ST_GAVE_UP  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_SLOT_TICKS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BACKOFF_LIMIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ATTEMPT_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_JAM_COUNT      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_JAM_VALUE      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SENSE_CODE     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FREE_CODE      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_COLLISION_CODE = 3'd7;

   // one burst of words: jam words first, then an optional tail word
   typedef struct packed {
      logic [JAM_W-1:0]  jams;
      logic [BYTE_W-1:0] jam_byte;
      logic              tail_present;
      logic [BYTE_W-1:0] tail_byte;
      logic              tail_tx;
      logic [1:0]        status;
      logic [SEQ_W-1:0]  seq;
      logic [COLL_W-1:0] coll;
      logic [ATT_W-1:0]  attempts;
   } burst_type;

endpackage

/* src/csmacd_ram.sv */
module csmacd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (write) begin
         mem_ff[waddr] <= wdata;
      end
      if (write && (waddr == raddr)) begin
         rdata_ff <= wdata;
      end else begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/csmacd_tx_out.sv */
module csmacd_tx_out (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  csmacd_pkg::burst_type      burst,
   output logic                       free,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [csmacd_pkg::BYTE_W-1:0] rsp_tx_byte,
   output logic                       rsp_tx_valid,
   output logic                       rsp_run_end,
   output logic [1:0]                 rsp_status,
   output logic [csmacd_pkg::SEQ_W-1:0]  rsp_sequence_now,
   output logic [csmacd_pkg::COLL_W-1:0] rsp_collisions_seen,
   output logic [csmacd_pkg::ATT_W-1:0]  rsp_attempt_now
);
   import csmacd_pkg::*;

   burst_type burst_ff;
   logic      busy_ff;
   logic      jam_word;
   logic      last_word;
   logic      accept;

   assign jam_word  = (burst_ff.jams != '0);
   assign last_word = jam_word ? ((burst_ff.jams == JAM_W'(1)) && !burst_ff.tail_present)
                               : 1'b1;
   assign accept    = busy_ff && !rsp_stall;
   assign free      = !busy_ff || (accept && last_word);

   assign rsp_valid           = busy_ff;
   assign rsp_tx_byte         = jam_word ? burst_ff.jam_byte : burst_ff.tail_byte;
   assign rsp_tx_valid        = jam_word ? 1'b1 : burst_ff.tail_tx;
   assign rsp_run_end         = last_word;
   assign rsp_status          = last_word ? burst_ff.status : ST_PROGRESS;
   assign rsp_sequence_now    = burst_ff.seq;
   assign rsp_collisions_seen = burst_ff.coll;
   assign rsp_attempt_now     = burst_ff.attempts;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load) begin
         busy_ff <= 1'b1;
      end else if (accept && last_word) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         burst_ff <= burst;
      end else if (accept && jam_word) begin
         burst_ff.jams <= burst_ff.jams - JAM_W'(1);
      end
   end

endmodule

/* src/csma_cd_transmit_controller_top.sv */
// CSMA/CD transmit controller with truncated binary exponential backoff. Frame
// bytes are loaded into a 256-byte store; the word that marks the frame end
// sends a sense byte, and channel replies and ticks then drive the send, the
// jam after a collision, the backoff wait and the final report. An accepted
// word passes an input register and is worked there, held while the output
// cannot take its result; a word giving one result or none leaves room for the
// next word at once, so one word a cycle is sustained while the output is not
// stalled. A collision gives a burst of up to jam_count (capped at 16) plus one
// result words, and the input waits until the last burst word is being taken.
// The frame store has a registered read kept pointing at the next byte to send.
module csma_cd_transmit_controller_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [csmacd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [csmacd_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_op,
   input  logic [7:0]                       req_frame_byte,
   input  logic                             req_frame_end,
   input  logic                             req_reply_present,
   input  logic [7:0]                       req_reply_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_tx_byte,
   output logic                             rsp_tx_valid,
   output logic                             rsp_run_end,
   output logic [1:0]                       rsp_status,
   output logic [7:0]                       rsp_sequence_now,
   output logic [15:0]                      rsp_collisions_seen,
   output logic [4:0]                       rsp_attempt_now
);
   import csmacd_pkg::*;

   typedef enum logic [2:0] {
      PH_LOAD,
      PH_SENSE,
      PH_BUSY,
      PH_SEND,
      PH_BACKOFF
   } phase_type;

   logic [SLOT_W-1:0]  slot_ticks_ff;
   logic [LIMIT_W-1:0] backoff_limit_ff;
   logic [ATT_W-1:0]   attempt_limit_ff;
   logic [JAM_W-1:0]   jam_count_ff;
   logic [BYTE_W-1:0]  jam_value_ff;
   logic [BYTE_W-1:0]  sense_code_ff;
   logic [BYTE_W-1:0]  free_code_ff;
   logic [BYTE_W-1:0]  collision_code_ff;

   logic               in_valid_ff;
   logic [1:0]         op_ff;
   logic [BYTE_W-1:0]  frame_byte_ff;
   logic               frame_end_ff;
   logic               reply_present_ff;
   logic [BYTE_W-1:0]  reply_value_ff;

   phase_type          phase_ff, phase_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   pos_ff, pos_in;
   logic [ATT_W-1:0]   att_ff, att_in;
   logic [LIMIT_W-1:0] wait_ff, wait_in;
   logic [LFSR_W-1:0]  lfsr_ff, lfsr_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [COLL_W-1:0]  coll_ff, coll_in;

   logic               ram_we;
   logic [BYTE_W-1:0]  ram_rdata;
   logic [LEN_W-1:0]   pos_next;

   logic               emit;
   logic               out_free;
   logic               proc_fire;
   burst_type          burst;

   logic [ATT_W-1:0]           att_inc;
   logic [LFSR_W-1:0]          lfsr_step;
   logic [EXP_W-1:0]           exp_k;
   logic [BACKOFF_EXP_CAP-1:0] rand_mask;
   logic [BACKOFF_EXP_CAP-1:0] rand_r;
   logic [DELAY_W-1:0]         delay_full;
   logic [LIMIT_W-1:0]         delay;
   logic [JAM_W-1:0]           jams;

   // backoff draw
   always_comb begin
      att_inc   = att_ff + ATT_W'(1);
      lfsr_step = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LFSR_TAPS) : (lfsr_ff >> 1);
      if ({{(32 - ATT_W){1'b0}}, att_inc} < BACKOFF_EXP_CAP) begin
         exp_k = EXP_W'(att_inc);
      end else begin
         exp_k = EXP_W'(BACKOFF_EXP_CAP);
      end
      rand_mask  = (BACKOFF_EXP_CAP'(1) << exp_k) - BACKOFF_EXP_CAP'(1);
      rand_r     = lfsr_step[BACKOFF_EXP_CAP-1:0] & rand_mask;
      delay_full = DELAY_W'(rand_r) * DELAY_W'(slot_ticks_ff);
      if (delay_full > DELAY_W'(backoff_limit_ff)) begin
         delay = backoff_limit_ff;
      end else begin
         delay = delay_full[LIMIT_W-1:0];
      end
      jams = (jam_count_ff > JAM_W'(MAX_JAM)) ? JAM_W'(MAX_JAM) : jam_count_ff;
   end

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      att_in   = att_ff;
      wait_in  = wait_ff;
      lfsr_in  = lfsr_ff;
      seq_in   = seq_ff;
      coll_in  = coll_ff;
      ram_we   = 1'b0;
      emit     = 1'b0;
      burst    = '0;
      burst.jam_byte = jam_value_ff;

      case (phase_ff)
         PH_LOAD: begin
            if (op_ff == OP_LOAD) begin
               if (len_ff < LEN_W'(FRAME_DEPTH)) begin
                  ram_we = 1'b1;
                  len_in = len_ff + LEN_W'(1);
               end
               if (frame_end_ff) begin
                  att_in   = '0;
                  pos_in   = '0;
                  phase_in = PH_SENSE;
                  emit     = 1'b1;
                  burst.tail_present = 1'b1;
                  burst.tail_byte    = sense_code_ff;
                  burst.tail_tx      = 1'b1;
               end
            end
         end
         PH_SENSE: begin
            if (op_ff == OP_REPLY) begin
               if (reply_present_ff && (reply_value_ff == free_code_ff)) begin
                  phase_in = PH_SEND;
                  pos_in   = LEN_W'(1);
                  emit     = 1'b1;
                  burst.tail_present = 1'b1;
                  burst.tail_byte    = ram_rdata;
                  burst.tail_tx      = 1'b1;
               end else if (slot_ticks_ff == '0) begin
                  emit = 1'b1;
                  burst.tail_present = 1'b1;
                  burst.tail_byte    = sense_code_ff;
                  burst.tail_tx      = 1'b1;
               end else begin
                  wait_in  = LIMIT_W'(slot_ticks_ff);
                  phase_in = PH_BUSY;
               end
            end
         end
         PH_SEND: begin
            if (op_ff == OP_REPLY) begin
               if (reply_present_ff && (reply_value_ff == collision_code_ff)) begin
                  coll_in    = coll_ff + COLL_W'(1);
                  att_in     = att_inc;
                  pos_in     = '0;
                  burst.jams = jams;
                  if (att_inc >= attempt_limit_ff) begin
                     // give up: status rides on the last jam word, or on a lone tail word when there are none
                     emit     = 1'b1;
                     burst.tail_present = (jams == '0);
                     burst.status       = ST_GAVE_UP;
                     phase_in = PH_LOAD;
                     len_in   = '0;
                     wait_in  = '0;
                  end else begin
                     lfsr_in = lfsr_step;
                     if (delay == '0) begin
                        phase_in = PH_SENSE;
                        emit     = 1'b1;
                        burst.tail_present = 1'b1;
                        burst.tail_byte    = sense_code_ff;
                        burst.tail_tx      = 1'b1;
                     end else begin
                        wait_in  = delay;
                        phase_in = PH_BACKOFF;
                        emit     = (jams != '0);
                     end
                  end
               end else if (pos_ff >= len_ff) begin
                  seq_in   = seq_ff + SEQ_W'(1);
                  emit     = 1'b1;
                  burst.tail_present = 1'b1;
                  burst.status       = ST_SENT;
                  phase_in = PH_LOAD;
                  len_in   = '0;
                  pos_in   = '0;
                  wait_in  = '0;
               end else begin
                  pos_in = pos_ff + LEN_W'(1);
                  emit   = 1'b1;
                  burst.tail_present = 1'b1;
                  burst.tail_byte    = ram_rdata;
                  burst.tail_tx      = 1'b1;
               end
            end
         end
         PH_BUSY, PH_BACKOFF: begin
            if (op_ff == OP_TICK) begin
               if (wait_ff <= LIMIT_W'(1)) begin
                  wait_in  = '0;
                  phase_in = PH_SENSE;
                  emit     = 1'b1;
                  burst.tail_present = 1'b1;
                  burst.tail_byte    = sense_code_ff;
                  burst.tail_tx      = 1'b1;
               end else begin
                  wait_in = wait_ff - LIMIT_W'(1);
               end
            end
         end
         default: begin
            phase_in = PH_LOAD;
         end
      endcase

      burst.seq      = seq_in;
      burst.coll     = coll_in;
      burst.attempts = att_in;
   end

   assign proc_fire = in_valid_ff && (!emit || out_free);
   assign req_stall = in_valid_ff && !proc_fire;
   assign pos_next  = proc_fire ? pos_in : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LOAD;
         len_ff   <= '0;
         pos_ff   <= '0;
         att_ff   <= '0;
         wait_ff  <= '0;
         lfsr_ff  <= LFSR_SEED;
         seq_ff   <= '0;
         coll_ff  <= '0;
      end else if (proc_fire) begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         att_ff   <= att_in;
         wait_ff  <= wait_in;
         lfsr_ff  <= lfsr_in;
         seq_ff   <= seq_in;
         coll_ff  <= coll_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (proc_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff            <= req_op;
         frame_byte_ff    <= req_frame_byte;
         frame_end_ff     <= req_frame_end;
         reply_present_ff <= req_reply_present;
         reply_value_ff   <= req_reply_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ticks_ff     <= SLOT_W'(10);
         backoff_limit_ff  <= LIMIT_W'(1000);
         attempt_limit_ff  <= ATT_W'(16);
         jam_count_ff      <= JAM_W'(4);
         jam_value_ff      <= BYTE_W'(170);
         sense_code_ff     <= BYTE_W'(5);
         free_code_ff      <= BYTE_W'(6);
         collision_code_ff <= BYTE_W'(21);
      end else if (csr_write) begin
         case (csr_index)
            REG_SLOT_TICKS:     slot_ticks_ff     <= csr_wdata[SLOT_W-1:0];
            REG_BACKOFF_LIMIT:  backoff_limit_ff  <= csr_wdata[LIMIT_W-1:0];
            REG_ATTEMPT_LIMIT:  attempt_limit_ff  <= csr_wdata[ATT_W-1:0];
            REG_JAM_COUNT:      jam_count_ff      <= csr_wdata[JAM_W-1:0];
            REG_JAM_VALUE:      jam_value_ff      <= csr_wdata[BYTE_W-1:0];
            REG_SENSE_CODE:     sense_code_ff     <= csr_wdata[BYTE_W-1:0];
            REG_FREE_CODE:      free_code_ff      <= csr_wdata[BYTE_W-1:0];
            REG_COLLISION_CODE: collision_code_ff <= csr_wdata[BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   csmacd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FRAME_DEPTH)
   ) u_frame_store (
      .clock (clock),
      .write (ram_we && proc_fire),
      .waddr (len_ff[ADDR_W-1:0]),
      .wdata (frame_byte_ff),
      .raddr (pos_next[ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   csmacd_tx_out u_tx_out (
      .clock               (clock),
      .reset               (reset),
      .load                (proc_fire && emit),
      .burst               (burst),
      .free                (out_free),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_tx_valid        (rsp_tx_valid),
      .rsp_run_end         (rsp_run_end),
      .rsp_status          (rsp_status),
      .rsp_sequence_now    (rsp_sequence_now),
      .rsp_collisions_seen (rsp_collisions_seen),
      .rsp_attempt_now     (rsp_attempt_now)
   );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import csmacd_pkg::*;

   typedef enum logic [2:0] {
      LINK_LOADING, LINK_SENSING, LINK_BUSY, LINK_SENDING, LINK_BACKOFF
   } link_phase_type;

   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        tx_valid;
      logic        run_end;
      logic [1:0]  status;
      logic [7:0]  sequence_now;
      logic [15:0] collisions_seen;
      logic [4:0]  attempt_now;
   } tx_word_type;

   // opcode with no meaning, always ignored
   localparam logic [1:0] OP_NONE = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_op = OP_LOAD;
   logic [7:0]           req_frame_byte = '0;
   logic                 req_frame_end = 1'b0;
   logic                 req_reply_present = 1'b0;
   logic [7:0]           req_reply_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_tx_byte;
   logic                 rsp_tx_valid;
   logic                 rsp_run_end;
   logic [1:0]           rsp_status;
   logic [7:0]           rsp_sequence_now;
   logic [15:0]          rsp_collisions_seen;
   logic [4:0]           rsp_attempt_now;

   // register mirror
   logic [SLOT_W-1:0]  cfg_slot_ticks;
   logic [LIMIT_W-1:0] cfg_backoff_limit;
   logic [ATT_W-1:0]   cfg_attempt_limit;
   logic [JAM_W-1:0]   cfg_jam_count;
   logic [7:0]         cfg_jam_value;
   logic [7:0]         cfg_sense_code;
   logic [7:0]         cfg_free_code;
   logic [7:0]         cfg_collision_code;

   // transmitter state as predicted
   logic [7:0]        frame_bytes [FRAME_DEPTH];
   int unsigned       frame_len;
   int unsigned       send_pos;
   int unsigned       wait_left;
   link_phase_type    link_phase;
   logic [ATT_W-1:0]  attempts;
   logic [LFSR_W-1:0] backoff_lfsr;
   logic [SEQ_W-1:0]  frame_seq;
   logic [COLL_W-1:0] collision_total;

   tx_word_type tx_due[$];
   int          errors_seen = 0;
   int unsigned link_words = 0;
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;

   csma_cd_transmit_controller_top DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_frame_byte      (req_frame_byte),
      .req_frame_end       (req_frame_end),
      .req_reply_present   (req_reply_present),
      .req_reply_value     (req_reply_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_tx_valid        (rsp_tx_valid),
      .rsp_run_end         (rsp_run_end),
      .rsp_status          (rsp_status),
      .rsp_sequence_now    (rsp_sequence_now),
      .rsp_collisions_seen (rsp_collisions_seen),
      .rsp_attempt_now     (rsp_attempt_now)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic void add_word(logic [7:0] value, logic valid, logic [1:0] status);
      tx_word_type w;
      w.tx_byte         = valid ? value : 8'd0;
      w.tx_valid        = valid;
      w.run_end         = 1'b0;
      w.status          = status;
      w.sequence_now    = frame_seq;
      w.collisions_seen = collision_total;
      w.attempt_now     = attempts;
      tx_due.push_back(w);
   endfunction

   function automatic void start_sense();
      link_phase = LINK_SENSING;
      add_word(cfg_sense_code, 1'b1, ST_PROGRESS);
   endfunction

   function automatic void start_wait(int unsigned ticks, link_phase_type wait_phase);
      if (ticks == 0) begin
         start_sense();
      end else begin
         wait_left  = ticks & 32'hFFFFF;
         link_phase = wait_phase;
      end
   endfunction

   function automatic void close_frame();
      link_phase = LINK_LOADING;
      frame_len  = 0;
      send_pos   = 0;
      wait_left  = 0;
   endfunction

   function automatic void predict_tx_words(logic [1:0] op, logic [7:0] fbyte, logic fend,
                                            logic present, logic [7:0] value);
      int unsigned due_at_start, jams, k, r, delay;
      tx_word_type w;
      due_at_start = tx_due.size();
      if (op == OP_LOAD && link_phase == LINK_LOADING) begin
         if (frame_len < FRAME_DEPTH) begin
            frame_bytes[frame_len[ADDR_W-1:0]] = fbyte;
            frame_len++;
         end
         if (fend) begin
            attempts = '0;
            send_pos = 0;
            start_sense();
         end
      end else if (op == OP_REPLY && link_phase == LINK_SENSING) begin
         if (present && value == cfg_free_code) begin
            send_pos   = 0;
            link_phase = LINK_SENDING;
            add_word(frame_bytes[0], 1'b1, ST_PROGRESS);
         end else begin
            start_wait(32'(cfg_slot_ticks), LINK_BUSY);
         end
      end else if (op == OP_REPLY && link_phase == LINK_SENDING) begin
         if (present && value == cfg_collision_code) begin
            jams = (32'(cfg_jam_count) > MAX_JAM) ? MAX_JAM : 32'(cfg_jam_count);
            collision_total++;
            attempts++;
            if (attempts >= cfg_attempt_limit) begin
               for (int unsigned i = 0; i < jams; i++) begin
                  add_word(cfg_jam_value, 1'b1, (i + 1 == jams) ? ST_GAVE_UP : ST_PROGRESS);
               end
               if (jams == 0) begin
                  add_word(8'd0, 1'b0, ST_GAVE_UP);
               end
               close_frame();
            end else begin
               for (int unsigned i = 0; i < jams; i++) begin
                  add_word(cfg_jam_value, 1'b1, ST_PROGRESS);
               end
               if (backoff_lfsr[0]) begin
                  backoff_lfsr = (backoff_lfsr >> 1) ^ LFSR_TAPS;
               end else begin
                  backoff_lfsr = backoff_lfsr >> 1;
               end
               k     = (32'(attempts) < BACKOFF_EXP_CAP) ? 32'(attempts) : BACKOFF_EXP_CAP;
               r     = 32'(backoff_lfsr) & ((32'd1 << k) - 32'd1);
               delay = r * 32'(cfg_slot_ticks);
               if (delay > 32'(cfg_backoff_limit)) begin
                  delay = 32'(cfg_backoff_limit);
               end
               start_wait(delay, LINK_BACKOFF);
            end
         end else begin
            send_pos++;
            if (send_pos >= frame_len || send_pos >= FRAME_DEPTH) begin
               frame_seq++;
               add_word(8'd0, 1'b0, ST_SENT);
               close_frame();
            end else begin
               add_word(frame_bytes[send_pos[ADDR_W-1:0]], 1'b1, ST_PROGRESS);
            end
         end
      end else if (op == OP_TICK && (link_phase == LINK_BUSY || link_phase == LINK_BACKOFF)) begin
         if (wait_left <= 1) begin
            wait_left = 0;
            start_sense();
         end else begin
            wait_left--;
         end
      end
      if (tx_due.size() > due_at_start) begin
         w         = tx_due[tx_due.size() - 1];
         w.run_end = 1'b1;
         tx_due[tx_due.size() - 1] = w;
      end
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errors_seen++;
      end
   endfunction

   always @(posedge clock) begin
      tx_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tx_due.size() == 0) begin
            $error("unexpected result word: tx_byte %0d status %0d", rsp_tx_byte, rsp_status);
            errors_seen++;
         end else begin
            want = tx_due.pop_front();
            check_field("tx_byte", 32'(want.tx_byte), 32'(rsp_tx_byte));
            check_field("tx_valid", 32'(want.tx_valid), 32'(rsp_tx_valid));
            check_field("run_end", 32'(want.run_end), 32'(rsp_run_end));
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("sequence_now", 32'(want.sequence_now), 32'(rsp_sequence_now));
            check_field("collisions_seen", 32'(want.collisions_seen),
                        32'(rsp_collisions_seen));
            check_field("attempt_now", 32'(want.attempt_now), 32'(rsp_attempt_now));
         end
      end
   end

   task automatic send_word(logic [1:0] op, logic [7:0] fbyte, logic fend,
                            logic present, logic [7:0] value);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_frame_byte    <= fbyte;
      req_frame_end     <= fend;
      req_reply_present <= present;
      req_reply_value   <= value;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_tx_words(op, fbyte, fend, present, value);
   endtask

   task automatic drain_results();
      int guard = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (tx_due.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (24) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         REG_SLOT_TICKS:     cfg_slot_ticks     = data[SLOT_W-1:0];
         REG_BACKOFF_LIMIT:  cfg_backoff_limit  = data[LIMIT_W-1:0];
         REG_ATTEMPT_LIMIT:  cfg_attempt_limit  = data[ATT_W-1:0];
         REG_JAM_COUNT:      cfg_jam_count      = data[JAM_W-1:0];
         REG_JAM_VALUE:      cfg_jam_value      = data[7:0];
         REG_SENSE_CODE:     cfg_sense_code     = data[7:0];
         REG_FREE_CODE:      cfg_free_code      = data[7:0];
         REG_COLLISION_CODE: cfg_collision_code = data[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic apply_setting(int unsigned slot, int unsigned blimit, int unsigned alimit,
                                int unsigned jcount, logic [7:0] jvalue, logic [7:0] sense,
                                logic [7:0] free, logic [7:0] coll);
      drain_results();
      write_reg(REG_SLOT_TICKS, CSR_W'(slot));
      write_reg(REG_BACKOFF_LIMIT, CSR_W'(blimit));
      write_reg(REG_ATTEMPT_LIMIT, CSR_W'(alimit));
      write_reg(REG_JAM_COUNT, CSR_W'(jcount));
      write_reg(REG_JAM_VALUE, CSR_W'(jvalue));
      write_reg(REG_SENSE_CODE, CSR_W'(sense));
      write_reg(REG_FREE_CODE, CSR_W'(free));
      write_reg(REG_COLLISION_CODE, CSR_W'(coll));
   endtask

   // a word the transmitter has no use for in its present phase
   task automatic send_noise();
      logic [1:0] op;
      op = 2'($urandom_range(3));
      while ((op == OP_LOAD && link_phase == LINK_LOADING)
             || (op == OP_REPLY && (link_phase == LINK_SENSING || link_phase == LINK_SENDING))
             || (op == OP_TICK && (link_phase == LINK_BUSY || link_phase == LINK_BACKOFF))) begin
         op = 2'($urandom_range(3));
      end
      send_word(op, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                8'($urandom_range(255)));
   endtask

   task automatic tick_until_sense();
      while (link_phase == LINK_BUSY || link_phase == LINK_BACKOFF) begin
         send_word(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 8'($urandom_range(255)));
      end
   endtask

   // loads one frame and answers the link until it is sent or abandoned
   task automatic drive_frame(int unsigned len, int unsigned free_pct, int unsigned coll_pct,
                              int unsigned noise_pct);
      logic [7:0] value;
      logic       present;
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(99) < noise_pct) begin
            send_noise();
         end
         send_word(OP_LOAD, 8'($urandom_range(255)), i + 1 == len, 1'($urandom_range(1)),
                   8'($urandom_range(255)));
         link_words++;
      end
      while (link_phase != LINK_LOADING) begin
         if ($urandom_range(99) < noise_pct) begin
            send_noise();
         end
         value   = 8'($urandom_range(255));
         present = ($urandom_range(3) != 0);
         case (link_phase)
            LINK_SENSING: begin
               if ($urandom_range(99) < free_pct) begin
                  present = 1'b1;
                  value   = cfg_free_code;
               end else if (present && value == cfg_free_code) begin
                  value = ~value;
               end
               send_word(OP_REPLY, 8'($urandom_range(255)), 1'($urandom_range(1)), present,
                         value);
            end
            LINK_SENDING: begin
               if ($urandom_range(99) < coll_pct) begin
                  present = 1'b1;
                  value   = cfg_collision_code;
               end else if (present && value == cfg_collision_code) begin
                  value = ~value;
               end
               send_word(OP_REPLY, 8'($urandom_range(255)), 1'($urandom_range(1)), present,
                         value);
            end
            default: begin
               send_word(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)), present,
                         value);
            end
         endcase
         link_words++;
      end
   endtask

   task automatic test_reset_defaults();
      send_word(OP_NONE, 8'hFF, 1'b1, 1'b1, 8'hFF);
      send_word(OP_TICK, 8'h00, 1'b0, 1'b0, 8'h00);
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, cfg_free_code);
      send_word(OP_LOAD, 8'h00, 1'b0, 1'b0, 8'h00);
      send_word(OP_LOAD, 8'hFF, 1'b1, 1'b0, 8'h00);
      // free code without a reply present still reads as busy
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b0, cfg_free_code);
      tick_until_sense();
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, cfg_free_code);
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b0, cfg_collision_code);
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, 8'h00);
   endtask

   task automatic test_collision_burst();
      // jam count above sixteen is cut, zero backoff senses straight after the jam
      apply_setting(1, 0, 2, 31, 8'hFF, 8'h00, 8'hFF, 8'h00);
      send_word(OP_LOAD, 8'h5A, 1'b1, 1'b0, 8'h00);
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, 8'hFF);
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, 8'h00);
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, 8'hFF);
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, 8'h00);
   endtask

   task automatic test_zero_waits();
      // zero slot, zero attempt limit and no jam words
      apply_setting(0, 16'hFFFF, 0, 0, 8'h00, 8'h5A, 8'hA5, 8'h3C);
      send_word(OP_LOAD, 8'hC3, 1'b1, 1'b0, 8'h00);
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, 8'h3C);
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, 8'hA5);
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, 8'h3C);
   endtask

   task automatic test_long_slot();
      apply_setting(1000, 3, 16, 1, 8'h81, 8'h05, 8'h06, 8'h15);
      send_word(OP_LOAD, 8'h3C, 1'b1, 1'b0, 8'h00);
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, 8'h06);
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, 8'h15);
      tick_until_sense();
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, 8'h06);
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, 8'h07);
   endtask

   task automatic test_full_store();
      // bytes past the store depth are dropped, the end marker still starts the send
      apply_setting(2, 40, 1, 4, 8'hAA, 8'h05, 8'h06, 8'h15);
      for (int unsigned i = 0; i <= FRAME_DEPTH; i++) begin
         send_word(OP_LOAD, 8'($urandom_range(255)), i == FRAME_DEPTH, 1'b0, 8'h00);
      end
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, 8'h06);
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, 8'h00);
      send_word(OP_REPLY, 8'h00, 1'b0, 1'b1, 8'h15);
   endtask

   task automatic test_random_traffic(int unsigned words, int unsigned gap, int unsigned stall);
      int unsigned target;
      target    = link_words + words;
      gap_pct   = gap;
      stall_pct = stall;
      while (link_words < target) begin
         drive_frame(($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1),
                     70, 20, 10);
      end
   endtask

   initial begin
      cfg_slot_ticks     = SLOT_W'(10);
      cfg_backoff_limit  = LIMIT_W'(1000);
      cfg_attempt_limit  = ATT_W'(16);
      cfg_jam_count      = JAM_W'(4);
      cfg_jam_value      = 8'd170;
      cfg_sense_code     = 8'd5;
      cfg_free_code      = 8'd6;
      cfg_collision_code = 8'd21;
      frame_len          = 0;
      send_pos           = 0;
      wait_left          = 0;
      link_phase         = LINK_LOADING;
      attempts           = '0;
      backoff_lfsr       = LFSR_SEED;
      frame_seq          = '0;
      collision_total    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_collision_burst();
      test_zero_waits();
      test_long_slot();
      test_full_store();

      apply_setting(1, 16'hFFFF, 16, 1, 8'hFF, 8'h00, 8'hFF, 8'h80);
      test_random_traffic(25, 0, 0);
      apply_setting(2, 0, 3, 16, 8'h00, 8'hFF, 8'h00, 8'hFF);
      test_random_traffic(25, 55, 0);
      apply_setting(3, 12, 5, 31, 8'h55, 8'd5, 8'd6, 8'd21);
      test_random_traffic(25, 0, 55);
      apply_setting(0, 1000, 4, 0, 8'h01, 8'h5A, 8'hA5, 8'h3C);
      test_random_traffic(25, 9, 9);

      drain_results();
      if (errors_seen == 0 && tx_due.size() == 0) begin
         $display("** csma_cd_transmit_controller_top: PASSED **");
      end else begin
         $display("** csma_cd_transmit_controller_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("** csma_cd_transmit_controller_top: FAILED **");
      $finish;
   end

endmodule
